>>> design/slsfc_pkg.sv
// Package: shared types and constants for the sync/length/sum-8 frame checker.
`default_nettype none

package slsfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 17;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned ReplyIdxW = 2;

  localparam logic [PosW-1:0]  PosMax      = '1;
  localparam logic [PosW:0]    HeaderBytes = 18'd4;
  localparam logic [PosW:0]    FrameOvhd   = 18'd5;

  localparam logic [ByteW-1:0] Sync1Reset  = 8'hAA;
  localparam logic [ByteW-1:0] Sync2Reset  = 8'h55;
  localparam logic [PosW-1:0]  MinChunkReset = 17'd6;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_SIZE  = 3'd1,
    ST_SYNC  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_CHECK = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_SYNC  = 2'd0,
    CFG_SECOND_SYNC = 2'd1,
    CFG_MIN_CHUNK   = 2'd2
  } cfg_idx_e;

  typedef enum logic [ReplyIdxW-1:0] {
    RB_SYNC1  = 2'd0,
    RB_SYNC2  = 2'd1,
    RB_STATUS = 2'd2,
    RB_SUM    = 2'd3
  } reply_idx_e;

endpackage

`default_nettype wire

>>> design/sync_length_sum8_frame_checker.sv
// Top level: frame parser, status decision and four-byte reply generator.
`default_nettype none

// Channel   | Direction | Payload                                   | Framing
// ----------+-----------+-------------------------------------------+-------------------------
// s_axis    | in        | tdata[7:0] data_byte                      | tlast = chunk_end
// m_axis    | out       | tdata[7:0] reply_byte, [10:8] frame_status| tlast = reply_last
// cfg       | in        | cfg_wdata_i, cfg_idx_i selects register   | cfg_we_i, no read-back
//
// Each received byte is held in an input register, then the parser state advances
// from it once the byte is consumed. A chunk end yields a status that queues in a
// two-slot buffer and leaves as four reply transfers, one per cycle while m_axis
// is ready. Input throughput is one byte per cycle; a chunk end stalls input only
// while both status slots are full. Reset clears the parser, the buffers and the
// registers to their defaults. Stalls on the reply side hold the reply byte and index.

module sync_length_sum8_frame_checker
  import slsfc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  // received bytes
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [7:0]        s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic              s_axis_tlast_i,  // chunk_end
  // reply bytes
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [15:0]            m_axis_tdata_o,  // [7:0] reply_byte, [10:8] frame_status
  output logic                   m_axis_tlast_o   // reply_last
);

  // Configuration registers
  logic [ByteW-1:0] sync1_q, sync2_q;
  logic [PosW-1:0]  min_chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q     <= Sync1Reset;
      sync2_q     <= Sync2Reset;
      min_chunk_q <= MinChunkReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_SYNC:  sync1_q     <= cfg_wdata_i[ByteW-1:0];
        CFG_SECOND_SYNC: sync2_q     <= cfg_wdata_i[ByteW-1:0];
        CFG_MIN_CHUNK:   min_chunk_q <= cfg_wdata_i[PosW-1:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             consume;
  logic             slot_free;

  assign consume         = in_valid_q && (!in_last_q || slot_free);
  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i[ByteW-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Parser state
  logic [PosW-1:0]  pos_q, pos_d;
  logic             mism_q, mism_d;
  logic [LenW-1:0]  pay_q, pay_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [PosW-1:0]  chunk_len;
  logic             bad_sync;
  status_e          status;

  always_comb begin
    mism_d = mism_q;
    pay_d  = pay_q;
    sum_d  = sum_q;
    chk_d  = chk_q;
    case (pos_q)
      17'd0: mism_d = mism_q | (in_byte_q != sync1_q);
      17'd1: mism_d = mism_q | (in_byte_q != sync2_q);
      17'd2: pay_d  = {in_byte_q, pay_q[7:0]};
      17'd3: pay_d  = {pay_q[15:8], in_byte_q};
      default: begin
        // payload bytes accumulate, the byte right after them is the checksum
        if ({1'b0, pos_q} < ({2'b00, pay_q} + HeaderBytes)) begin
          sum_d = sum_q + in_byte_q;
        end else if ({1'b0, pos_q} == ({2'b00, pay_q} + HeaderBytes)) begin
          chk_d = in_byte_q;
        end
      end
    endcase
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 17'd1;
  end

  // Status in check order; a chunk of one byte compares its missing second sync as zero
  assign chunk_len = pos_d;
  assign bad_sync  = mism_d || ((chunk_len < 17'd2) && (sync2_q != '0));

  always_comb begin
    if (chunk_len < min_chunk_q) begin
      status = ST_SIZE;
    end else if (bad_sync) begin
      status = ST_SYNC;
    end else if (pay_d == '0) begin
      status = ST_EMPTY;
    end else if ({1'b0, chunk_len} < ({2'b00, pay_d} + FrameOvhd)) begin
      status = ST_SIZE;
    end else if (sum_d != chk_d) begin
      status = ST_CHECK;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
      pay_q  <= '0;
      sum_q  <= '0;
      chk_q  <= '0;
    end else if (consume) begin
      if (in_last_q) begin
        // chunk closed: clear for the next one
        pos_q  <= '0;
        mism_q <= 1'b0;
        pay_q  <= '0;
        sum_q  <= '0;
        chk_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        mism_q <= mism_d;
        pay_q  <= pay_d;
        sum_q  <= sum_d;
        chk_q  <= chk_d;
      end
    end
  end

  // Status buffer: a waiting slot feeds the slot being sent
  logic          nxt_valid_q, cur_valid_q;
  status_e       nxt_status_q, cur_status_q;
  reply_idx_e    cur_idx_q;
  logic          cur_done, promote, push;

  assign cur_done  = cur_valid_q && m_axis_tready_i && (cur_idx_q == RB_SUM);
  assign promote   = nxt_valid_q && (!cur_valid_q || cur_done);
  assign slot_free = !nxt_valid_q || promote;
  assign push      = consume && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_valid_q <= 1'b0;
      cur_valid_q <= 1'b0;
      cur_idx_q   <= RB_SYNC1;
    end else begin
      if (push) begin
        nxt_valid_q <= 1'b1;
      end else if (promote) begin
        nxt_valid_q <= 1'b0;
      end
      if (promote) begin
        cur_valid_q <= 1'b1;
        cur_idx_q   <= RB_SYNC1;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
        cur_idx_q   <= RB_SYNC1;
      end else if (cur_valid_q && m_axis_tready_i) begin
        cur_idx_q   <= reply_idx_e'(cur_idx_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      nxt_status_q <= status;
    end
    if (promote) begin
      cur_status_q <= nxt_status_q;
    end
  end

  // Reply byte selection
  logic [ByteW-1:0] reply_byte;
  logic [ByteW-1:0] reply_sum;

  assign reply_sum = sync1_q + sync2_q + {{(ByteW-StatusW){1'b0}}, cur_status_q};

  always_comb begin
    case (cur_idx_q)
      RB_SYNC1:  reply_byte = sync1_q;
      RB_SYNC2:  reply_byte = sync2_q;
      RB_STATUS: reply_byte = {{(ByteW-StatusW){1'b0}}, cur_status_q};
      RB_SUM:    reply_byte = reply_sum;
      default:   reply_byte = sync1_q;
    endcase
  end

  assign m_axis_tvalid_o = cur_valid_q;
  assign m_axis_tdata_o  = {5'b00000, cur_status_q, reply_byte};
  assign m_axis_tlast_o  = (cur_idx_q == RB_SUM);

endmodule

`default_nettype wire

>>> design/slsfc_checker.sv
// Checker: port-level properties of the frame checker, bound to the top level.
`default_nettype none

module slsfc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // hold a stalled reply
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("reply valid dropped under stall");

  // a reply runs its four transfers without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside a reply");

  // status stays fixed across one reply
  a_status_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o
      |=> m_axis_tdata_o[10:8] == $past(m_axis_tdata_o[10:8]))
    else $error("status changed within a reply");

  // status code in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[10:8] <= 3'd4))
    else $error("status code out of range");

endmodule

bind sync_length_sum8_frame_checker slsfc_checker u_slsfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

>>> tb/sv/tb_sync_length_sum8_frame_checker.sv
// Testbench: random and directed chunks through the sync/length/sum-8 frame checker.
`timescale 1ns / 100ps

module tb_sync_length_sum8_frame_checker
  import slsfc_pkg::*;
();

  // Frame geometry as seen by the checker: 4 header bytes, then payload, then the sum byte
  localparam int unsigned TbHdrBytes   = 4;
  localparam int unsigned TbOvhdBytes  = 5;
  localparam int unsigned TbPosCap     = 131071;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 20;
  // index 3 is not mapped to any register; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i = '0;
  logic              s_axis_tlast_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [15:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;

  sync_length_sum8_frame_checker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bytes waiting to be driven, and reply transfers the checker still owes us
  rx_byte_t    rx_bytes_q[$];
  reply_t      replies_due[$];
  logic [7:0]  chunk_buf[$];

  int unsigned bytes_issued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned tx_idle_pct = 6;
  int unsigned rx_idle_pct = 54;
  logic        byte_taken = 1'b0;
  rx_byte_t    head_byte;
  reply_t      want;

  // Register mirror, kept in step with every write we issue
  logic [7:0]      sync1_m = Sync1Reset;
  logic [7:0]      sync2_m = Sync2Reset;
  logic [CfgW-1:0] min_chunk_m = MinChunkReset;

  // Per-chunk parse state of the checker
  logic [PosW-1:0] fr_pos = '0;
  logic            fr_sync_bad = 1'b0;
  logic [15:0]     fr_len_field = '0;
  logic [7:0]      fr_sum = '0;
  logic [7:0]      fr_check = '0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("tb: %s mismatch at %0t: got 0x%0h, expected 0x%0h",
             what, $realtime, got, exp_val);
    mismatches++;
  endtask

  // Advance the frame parse by one byte; on the chunk end, decide the status
  // and queue the four reply transfers it produces.
  task automatic track_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned len;
    logic        bad_sync;
    status_e     st;
    logic [7:0]  r0, r1, r2, r3;
    pos = fr_pos;
    if (pos == 0) begin
      if (b != sync1_m) fr_sync_bad = 1'b1;
    end else if (pos == 1) begin
      if (b != sync2_m) fr_sync_bad = 1'b1;
    end else if (pos == 2) begin
      fr_len_field[15:8] = b;
    end else if (pos == 3) begin
      fr_len_field[7:0] = b;
    end else if (pos < TbHdrBytes + fr_len_field) begin
      fr_sum = fr_sum + b;
    end else if (pos == TbHdrBytes + fr_len_field) begin
      fr_check = b;
    end
    // the position counter saturates; after the increment it equals the chunk length
    if (pos < TbPosCap) fr_pos = PosW'(pos + 1);
    if (last) begin
      len = fr_pos;
      // a missing second sync byte is compared as zero
      bad_sync = fr_sync_bad || (len < 2 && sync2_m != 8'h00);
      if (len < min_chunk_m) st = ST_SIZE;
      else if (bad_sync) st = ST_SYNC;
      else if (fr_len_field == 16'h0000) st = ST_EMPTY;
      else if (len < TbOvhdBytes + fr_len_field) st = ST_SIZE;
      else if (fr_sum != fr_check) st = ST_CHECK;
      else st = ST_OK;
      r0 = sync1_m;
      r1 = sync2_m;
      r2 = 8'(st);
      r3 = r0 + r1 + r2;
      replies_due.push_back('{data: r0, status: st, last: 1'b0});
      replies_due.push_back('{data: r1, status: st, last: 1'b0});
      replies_due.push_back('{data: r2, status: st, last: 1'b0});
      replies_due.push_back('{data: r3, status: st, last: 1'b1});
      fr_pos       = '0;
      fr_sync_bad  = 1'b0;
      fr_len_field = '0;
      fr_sum       = '0;
      fr_check     = '0;
    end
  endtask

  // Move the assembled chunk into the send queue, tagging its final byte
  task automatic flush_chunk();
    foreach (chunk_buf[i]) begin
      rx_bytes_q.push_back('{data: chunk_buf[i], last: (i == chunk_buf.size() - 1)});
    end
    bytes_issued += chunk_buf.size();
    chunk_buf.delete();
  endtask

  // Half well-formed frames with random payload; the rest corrupted or pure noise
  task automatic random_chunk();
    int unsigned kind;
    logic [15:0] plen;
    logic [7:0]  sum8;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    chunk_buf.delete();
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) chunk_buf.push_back(8'($urandom));
    end else begin
      plen = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
      chunk_buf.push_back(sync1_m);
      chunk_buf.push_back(sync2_m);
      chunk_buf.push_back(plen[15:8]);
      chunk_buf.push_back(plen[7:0]);
      sum8 = '0;
      repeat (plen) begin
        b = 8'($urandom);
        sum8 = sum8 + b;
        chunk_buf.push_back(b);
      end
      chunk_buf.push_back(sum8);
      // trailing bytes after the sum must be ignored
      repeat ($urandom_range(0, 2)) chunk_buf.push_back(8'($urandom));
      if (kind >= 65) begin
        case ($urandom_range(0, 5))
          0: chunk_buf[0] = chunk_buf[0] ^ 8'($urandom_range(1, 255));
          1: chunk_buf[1] = chunk_buf[1] ^ 8'($urandom_range(1, 255));
          2: begin
            chunk_buf[0] = chunk_buf[0] ^ 8'($urandom_range(1, 255));
            chunk_buf[1] = chunk_buf[1] ^ 8'($urandom_range(1, 255));
          end
          3: chunk_buf[TbHdrBytes + plen] = chunk_buf[TbHdrBytes + plen]
                                            ^ 8'($urandom_range(1, 255));
          4: repeat ($urandom_range(1, chunk_buf.size() - 1)) void'(chunk_buf.pop_back());
          default: begin
            chunk_buf[2] = 8'($urandom);
            chunk_buf[3] = 8'($urandom);
          end
        endcase
      end
    end
    flush_chunk();
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned start;
    start = bytes_issued;
    while (bytes_issued - start < budget) random_chunk();
  endtask

  // Hold one write for a single clock; the caller drops the enable afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_FIRST_SYNC:  sync1_m = value[7:0];
      CFG_SECOND_SYNC: sync2_m = value[7:0];
      CFG_MIN_CHUNK:   min_chunk_m = value;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every byte to be taken and every reply to arrive, then let the
  // pipeline empty before touching the registers.
  task automatic settle();
    while (bytes_accepted != bytes_issued || replies_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sender: hold a byte until it is taken, then fetch the next one or idle
  always @(negedge clk_i) begin
    if (!s_axis_tvalid_i || byte_taken) begin
      if (rst_ni && rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        head_byte = rx_bytes_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= head_byte.data;
        s_axis_tlast_i  <= head_byte.last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor: predict on each accepted byte, check each reply transfer,
  // and give up if nothing moves for too long.
  always @(posedge clk_i) begin
    byte_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      track_byte(s_axis_tdata_i, s_axis_tlast_i);
      bytes_accepted++;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply", m_axis_tdata_o, 0);
      end else begin
        want = replies_due.pop_front();
        if (m_axis_tdata_o[7:0] !== want.data)
          report_mismatch("reply_byte", m_axis_tdata_o[7:0], want.data);
        if (m_axis_tdata_o[10:8] !== want.status)
          report_mismatch("frame_status", m_axis_tdata_o[10:8], want.status);
        if (m_axis_tlast_o !== want.last)
          report_mismatch("reply_last", m_axis_tlast_o, want.last);
        if (m_axis_tdata_o[15:11] !== 5'b0)
          report_mismatch("tdata padding", m_axis_tdata_o[15:11], 0);
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: good frame with extreme payload, bad sum, one-byte chunk,
    // wrong second sync, empty payload.
    chunk_buf = '{8'hAA, 8'h55, 8'h00, 8'h01, 8'hFF, 8'hFF};
    flush_chunk();
    chunk_buf = '{8'hAA, 8'h55, 8'h00, 8'h01, 8'h00, 8'h01};
    flush_chunk();
    chunk_buf = '{8'h00};
    flush_chunk();
    chunk_buf = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h07, 8'h07};
    flush_chunk();
    chunk_buf = '{8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_chunk();
    random_traffic(25);
    settle();

    // Swap the idling sides; drop the minimum size to zero so that missing
    // header bytes are read as zero, with a zero second sync.
    tx_idle_pct = 54;
    rx_idle_pct = 6;
    write_reg(CFG_FIRST_SYNC, {9'h1FF, 8'hFF});
    write_reg(CFG_SECOND_SYNC, {9'h0AA, 8'h00});
    write_reg(CFG_MIN_CHUNK, 17'd0);
    write_reg(CfgIdxSpare, 17'($urandom));
    end_writes();
    chunk_buf = '{8'hFF};
    flush_chunk();
    chunk_buf = '{8'hFF, 8'h00, 8'h00};
    flush_chunk();
    random_traffic(15);
    settle();

    // Minimum chunk size of 5, the frame overhead; sync bytes 0x00 then 0xFF
    write_reg(CFG_FIRST_SYNC, {9'h000, 8'h00});
    write_reg(CFG_SECOND_SYNC, {9'h155, 8'hFF});
    write_reg(CFG_MIN_CHUNK, 17'd5);
    end_writes();
    chunk_buf = '{8'h00};
    flush_chunk();
    random_traffic(15);
    settle();

    // No idling from here. Minimum of 65540: every random chunk fails on size.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_FIRST_SYNC, 17'($urandom));
    write_reg(CFG_SECOND_SYNC, 17'($urandom));
    write_reg(CFG_MIN_CHUNK, 17'd65540);
    end_writes();
    random_traffic(15);
    settle();

    // Tiny minimum with a non-zero second sync: a lone first byte is a sync error
    write_reg(CFG_FIRST_SYNC, 17'($urandom));
    write_reg(CFG_SECOND_SYNC, 17'($urandom_range(1, 255)));
    write_reg(CFG_MIN_CHUNK, 17'd1);
    end_writes();
    chunk_buf = '{sync1_m};
    flush_chunk();
    random_traffic(10);

    while (bytes_accepted != bytes_issued || replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/slsfc_pkg.sv
design/sync_length_sum8_frame_checker.sv
design/slsfc_checker.sv
tb/sv/tb_sync_length_sum8_frame_checker.sv
